/* hw/rtl/tuning_tap_window_select_core_assert.svh */
// ---------------------------------------------------------------------------
// Tuning tap window select: assertion macros
// Shared concurrent assertion forms for the tap window selector.
// ---------------------------------------------------------------------------
`ifndef TUNING_TAP_WINDOW_SELECT_CORE_ASSERT_SVH
`define TUNING_TAP_WINDOW_SELECT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ttws_pkg.sv */
// ---------------------------------------------------------------------------
// Tuning tap window select: package
// Widths, register indexes and the window record shared by the modules.
// ---------------------------------------------------------------------------
package ttws_pkg;

    localparam int C_TAP_W    = 8;
    localparam int C_CNT_W    = 9;
    localparam int C_CFG_W    = 9;
    localparam int C_REG_IDX_W = 1;

    localparam logic [C_TAP_W-1:0] C_MAX_TAPS      = 8'd255;
    localparam logic [C_TAP_W-1:0] C_TAP_COUNT_RST = 8'd8;
    localparam logic [C_CNT_W-1:0] C_MIN_WIN_RST   = 9'd3;
    localparam logic [C_CNT_W-1:0] C_CNT_MAX       = 9'h1ff;

    localparam logic [C_REG_IDX_W-1:0] C_REG_TAP_COUNT  = 1'b0;
    localparam logic [C_REG_IDX_W-1:0] C_REG_MIN_WINDOW = 1'b1;

    typedef struct packed {
        logic [C_CNT_W-1:0] start;
        logic [C_CNT_W-1:0] length;
    } t_window;

endpackage

/* hw/rtl/ttws_run_tracker.sv */
// ---------------------------------------------------------------------------
// Tuning tap window select: run tracker
// Follows the open passing run and the longest run of one scan.
// ---------------------------------------------------------------------------
module ttws_run_tracker import ttws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  logic    i_tap_failed,
    input  logic    i_last_sample,
    output t_window o_window
);

    logic [C_CNT_W-1:0] r_index, n_index;
    logic [C_CNT_W-1:0] r_run,   n_run;
    t_window            r_best,  n_best;

    logic [C_CNT_W-1:0] w_run1;
    t_window            w_best1;
    t_window            w_best2;

    always_comb begin
        w_best1 = r_best;
        if (i_tap_failed) begin
            w_run1 = '0;
            if (r_run > r_best.length) begin
                w_best1.start  = r_index - r_run;
                w_best1.length = r_run;
            end
        end else begin
            w_run1 = (r_run == C_CNT_MAX) ? r_run : r_run + 9'd1;
        end

        // The final item closes the open run one past its own position.
        w_best2 = w_best1;
        if (w_run1 > w_best1.length) begin
            w_best2.start  = r_index + 9'd1 - w_run1;
            w_best2.length = w_run1;
        end

        n_index = r_index;
        n_run   = r_run;
        n_best  = r_best;
        if (i_take) begin
            if (i_last_sample) begin
                n_index = '0;
                n_run   = '0;
                n_best  = '0;
            end else begin
                n_index = (r_index == C_CNT_MAX) ? r_index : r_index + 9'd1;
                n_run   = w_run1;
                n_best  = w_best1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_run   <= '0;
            r_best  <= '0;
        end else begin
            r_index <= n_index;
            r_run   <= n_run;
            r_best  <= n_best;
        end
    end

    assign o_window = w_best2;

endmodule

/* hw/rtl/tuning_tap_window_select_core.sv */
// ---------------------------------------------------------------------------
// Tuning tap window select core
// Picks the center of the longest passing run from a sampling tap scan.
// ---------------------------------------------------------------------------
// The block takes one tap tuning result per clock cycle while tready is
// high, with tlast on the final result of the scan, and sends one result per
// scan: the center tap of the longest passing run, a pass flag and the run
// length. The run counters are updated in the cycle a request is taken, the
// closed window is held in a middle register, and the center is computed
// into the output register. Both sides stall independently through the
// middle and output registers. Configuration must be written by the user
// only while no scan is in flight; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module tuning_tap_window_select_core import ttws_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [C_REG_IDX_W-1:0] i_cfg_index,
    input  logic [C_CFG_W-1:0]     i_cfg_data,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [0] tap_failed, [7:1] zero
    input  logic                   i_s_axis_tlast,   // last_sample

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [23:0]            o_m_axis_tdata,   // [7:0] tap_select,
                                                     // [16:8] window_length
    output logic                   o_m_axis_tuser    // window_ok
);

    `include "tuning_tap_window_select_core_assert.svh"

    logic [C_TAP_W-1:0] r_tap_count;
    logic [C_CNT_W-1:0] r_min_window;

    logic               r_mid_valid;
    t_window            r_mid;
    logic               r_out_valid;
    logic [C_TAP_W-1:0] r_out_sel;
    logic               r_out_ok;
    logic [C_CNT_W-1:0] r_out_len;

    logic               w_take;
    logic               w_mid_adv;
    t_window            w_window;
    logic [C_TAP_W-1:0] w_cfg_tap;

    logic [10:0]        w_sum;
    logic [9:0]         w_mid;
    logic [9:0]         w_red;
    logic               w_ok;
    logic [C_TAP_W-1:0] w_sel;

    assign w_mid_adv       = r_mid_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_mid_valid || w_mid_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    ttws_run_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_tap_failed  (i_s_axis_tdata[0]),
        .i_last_sample (i_s_axis_tlast),
        .o_window      (w_window)
    );

    assign w_cfg_tap = i_cfg_data[C_TAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= C_TAP_COUNT_RST;
            r_min_window <= C_MIN_WIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_TAP_COUNT: begin
                    r_tap_count <= (w_cfg_tap > C_MAX_TAPS) ? C_MAX_TAPS : w_cfg_tap;
                end
                C_REG_MIN_WINDOW: begin
                    r_min_window <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_sum = {1'b0, r_mid.start, 1'b0} + {2'b00, r_mid.length} - 11'd1;
        w_mid = w_sum[10:1];
        if (r_tap_count != '0 && w_mid >= {2'b00, r_tap_count}) begin
            w_red = w_mid - {2'b00, r_tap_count};
        end else begin
            w_red = w_mid;
        end
        w_ok  = r_mid.length >= r_min_window;
        w_sel = (w_ok && r_mid.length != '0) ? w_red[C_TAP_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && i_s_axis_tlast) begin
                r_mid_valid <= 1'b1;
            end else if (w_mid_adv) begin
                r_mid_valid <= 1'b0;
            end
            if (w_mid_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_s_axis_tlast) begin
            r_mid <= w_window;
        end
        if (w_mid_adv) begin
            r_out_sel <= w_sel;
            r_out_ok  <= w_ok;
            r_out_len <= r_mid.length;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_len, r_out_sel};
    assign o_m_axis_tuser  = r_out_ok;

    `TTWS_ASSERT_NOW(a_ok_meets_min, o_m_axis_tvalid && o_m_axis_tuser,
        o_m_axis_tdata[16:8] >= r_min_window, "window_ok set below minimum window")

    `TTWS_ASSERT_NOW(a_fail_sel_zero, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tdata[7:0] == 8'd0, "failed result carries a nonzero tap")

    `TTWS_ASSERT_NEXT(a_mid_held, r_mid_valid && !w_mid_adv,
        r_mid_valid && $stable(r_mid), "stalled window lost from middle register")

endmodule
